/* design/bmhpq_pkg.sv */
package bmhpq_pkg;

   localparam int unsigned REQ_KEY_W   = 32;
   localparam int unsigned RSP_CNT_W   = 11;
   localparam int unsigned RSP_STAT_W  = 2;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [RSP_STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [RSP_STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [RSP_STAT_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                 req_type;
      logic [REQ_KEY_W-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic [RSP_STAT_W-1:0] status;
      logic [REQ_KEY_W-1:0]  popped_key;
      logic [REQ_KEY_W-1:0]  top_key;
      logic                  top_valid;
      logic [RSP_CNT_W-1:0]  count;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_LOAD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd_last;
      logic rd_parent;
      logic load_hole;
      logic up_move;
      logic dn_move;
      logic write_hole;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic is_push;
      logic full;
      logic empty;
      logic count_zero;
      logic count_one;
      logic parent_less;
      logic parent_root;
      logic dn_stop;
      logic big_is_pos;
   } stat_type;

endpackage

/* design/bmhpq_ctrl.sv */
module bmhpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   input  bmhpq_pkg::stat_type stat,
   output bmhpq_pkg::cmd_type  cmd
);
   import bmhpq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (stat.is_push) begin
                  if (stat.full)            state_in = ST_DONE;
                  else if (stat.count_zero) state_in = ST_FIN;
                  else                      state_in = ST_UP_RD;
               end else begin
                  if (stat.empty || stat.count_one) state_in = ST_DONE;
                  else                              state_in = ST_POP_RD;
               end
            end
         end
         ST_UP_RD:    state_in = ST_UP_CMP;
         ST_UP_CMP: begin
            if (stat.parent_less && !stat.parent_root) state_in = ST_UP_RD;
            else                                       state_in = ST_FIN;
         end
         ST_POP_RD:   state_in = ST_POP_LOAD;
         ST_POP_LOAD: state_in = ST_DN_RD;
         ST_DN_RD: begin
            if (stat.dn_stop) state_in = ST_FIN;
            else              state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            if (stat.big_is_pos) state_in = ST_FIN;
            else                 state_in = ST_DN_RD;
         end
         ST_FIN:      state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:     cmd.accept     = start;
         ST_UP_RD:    cmd.rd_parent  = 1'b1;
         ST_UP_CMP:   cmd.up_move    = stat.parent_less;
         ST_POP_RD:   cmd.rd_last    = 1'b1;
         ST_POP_LOAD: cmd.load_hole  = 1'b1;
         ST_DN_RD:    cmd            = '0;
         ST_DN_CMP:   cmd.dn_move    = !stat.big_is_pos;
         ST_FIN:      cmd.write_hole = 1'b1;
         ST_DONE:     cmd.respond    = 1'b1;
         default:     cmd            = '0;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/bmhpq_dp.sv */
module bmhpq_dp #(
   parameter int unsigned CAPACITY  = 1024,
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bmhpq_pkg::req_item_type req_item,
   input  logic                    csr_valid,
   input  logic                    csr_key_signed,
   input  bmhpq_pkg::cmd_type      cmd,
   output bmhpq_pkg::stat_type     stat,
   output bmhpq_pkg::rsp_item_type rsp_item
);
   import bmhpq_pkg::*;

   localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
   localparam int unsigned CHILD_W = ADDR_W + 1;
   localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

   logic [KEY_WIDTH-1:0] heap_mem [CAPACITY];

   logic                  key_signed_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [KEY_WIDTH-1:0]  hole_ff, hole_in;
   logic [KEY_WIDTH-1:0]  root_ff;
   logic [KEY_WIDTH-1:0]  rdata_a_ff, rdata_b_ff;
   logic [RSP_STAT_W-1:0] status_ff, status_in;
   logic [KEY_WIDTH-1:0]  popped_ff, popped_in;
   rsp_item_type          rsp_item_ff;

   logic [KEY_WIDTH-1:0]  sign_flip;
   logic [ADDR_W-1:0]     parent;
   logic [CHILD_W-1:0]    left, right;
   logic [CHILD_W-1:0]    count_ext;
   logic                  right_ok, l_win, r_win_h, r_gt_l, take_right;
   logic [ADDR_W-1:0]     big_idx;
   logic [KEY_WIDTH-1:0]  big_data;
   logic                  we;
   logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;
   logic [KEY_WIDTH-1:0]  wdata;
   logic                  is_push, full, empty;

   function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                     input logic [KEY_WIDTH-1:0] b,
                                     input logic [KEY_WIDTH-1:0] flip);
      return (a ^ flip) < (b ^ flip);
   endfunction

   assign sign_flip = {KEY_WIDTH{key_signed_ff}} & SIGN_MASK;
   assign parent    = (pos_ff - ADDR_W'(1)) >> 1;
   assign left      = {pos_ff, 1'b1};
   assign right     = left + CHILD_W'(1);
   assign count_ext = CHILD_W'(count_ff);
   assign right_ok  = right < count_ext;

   // Three compares side by side; the larger child wins only if it beats the hole.
   assign l_win      = key_less(hole_ff, rdata_a_ff, sign_flip);
   assign r_win_h    = key_less(hole_ff, rdata_b_ff, sign_flip);
   assign r_gt_l     = key_less(rdata_a_ff, rdata_b_ff, sign_flip);
   assign take_right = right_ok && (l_win ? r_gt_l : r_win_h);
   assign big_idx    = take_right ? ADDR_W'(right) : ADDR_W'(left);
   assign big_data   = take_right ? rdata_b_ff : rdata_a_ff;

   assign is_push = (req_item.req_type == REQ_PUSH);
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);

   always_comb begin
      stat.is_push     = is_push;
      stat.full        = full;
      stat.empty       = empty;
      stat.count_zero  = empty;
      stat.count_one   = (count_ff == CNT_W'(1));
      stat.parent_less = key_less(rdata_a_ff, hole_ff, sign_flip);
      stat.parent_root = (parent == '0);
      stat.dn_stop     = (left >= count_ext);
      stat.big_is_pos  = !(l_win || (right_ok && r_win_h));
   end

   always_comb begin
      we    = cmd.up_move || cmd.dn_move || cmd.write_hole;
      waddr = pos_ff;
      if (cmd.up_move)      wdata = rdata_a_ff;
      else if (cmd.dn_move) wdata = big_data;
      else                  wdata = hole_ff;
      if (cmd.rd_last)        raddr_a = ADDR_W'(count_ff);
      else if (cmd.rd_parent) raddr_a = parent;
      else                    raddr_a = ADDR_W'(left);
      raddr_b = ADDR_W'(right);
   end

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      hole_in   = hole_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      if (cmd.accept) begin
         status_in = STATUS_OK;
         popped_in = '0;
         if (is_push) begin
            hole_in = KEY_WIDTH'(req_item.key);
            pos_in  = ADDR_W'(count_ff);
            if (full) status_in = STATUS_FULL;
            else      count_in  = count_ff + CNT_W'(1);
         end else begin
            pos_in = '0;
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               popped_in = root_ff;
               count_in  = count_ff - CNT_W'(1);
            end
         end
      end
      if (cmd.load_hole) hole_in = rdata_a_ff;
      if (cmd.up_move)   pos_in  = parent;
      if (cmd.dn_move)   pos_in  = big_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_signed_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (csr_valid) key_signed_ff <= csr_key_signed;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      hole_ff   <= hole_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
      if (we && waddr == '0) root_ff <= wdata;
      if (cmd.respond) begin
         rsp_item_ff.status     <= status_ff;
         rsp_item_ff.popped_key <= REQ_KEY_W'(popped_ff);
         rsp_item_ff.top_key    <= empty ? '0 : REQ_KEY_W'(root_ff);
         rsp_item_ff.top_valid  <= !empty;
         rsp_item_ff.count      <= RSP_CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (we) heap_mem[waddr] <= wdata;
      rdata_a_ff <= heap_mem[raddr_a];
      rdata_b_ff <= heap_mem[raddr_b];
   end

   assign rsp_item = rsp_item_ff;

endmodule

/* design/binary_max_heap_priority_queue_unit.sv */
// Channel   Handshake                 Payload
// request   start / busy              req_item  (req_type, key)
// response  rsp_valid, one cycle      rsp_item  (status, popped_key, top_key, top_valid, count)
// csr       csr_valid / csr_ready     csr_key_signed
//
// One item at a time: a push moves its key up until it reaches the root or its parent is not
// smaller; a pop loads the last key as the hole and moves it down until it runs out of children
// or is no smaller than them. A key moves at most floor(log2(CAPACITY)) levels.
// Each level is a registered memory read and then a compare-and-write state.
// Refused pushes, pops on an empty heap and pops that empty it skip the walk and respond.
// Reset is synchronous and empties the heap; the store itself is not cleared.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
module binary_max_heap_priority_queue_unit #(
   parameter int unsigned CAPACITY  = 1024,
   parameter int unsigned KEY_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  bmhpq_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   output bmhpq_pkg::rsp_item_type rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_key_signed
);
   import bmhpq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   bmhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   bmhpq_dp #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_item       (req_item),
      .csr_valid      (csr_valid),
      .csr_key_signed (csr_key_signed),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_item       (rsp_item)
   );

endmodule

/* bench/binary_max_heap_priority_queue_unit_test.sv */
module binary_max_heap_priority_queue_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bmhpq_pkg::*;

   localparam int unsigned DEPTH         = 1024;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned STALL_LIMIT   = 2000;

   logic         clock          = 1'b0;
   logic         reset          = 1'b1;
   logic         start          = 1'b0;
   logic         busy;
   req_item_type req_item       = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_valid      = 1'b0;
   logic         csr_ready;
   logic         csr_key_signed = 1'b0;

   always #6 clock = ~clock;

   binary_max_heap_priority_queue_unit #(
      .CAPACITY  (DEPTH),
      .KEY_WIDTH (REQ_KEY_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_key_signed (csr_key_signed)
   );

   // Mirror of the heap, updated as each item is accepted.
   logic [REQ_KEY_W-1:0] heap_keys [DEPTH];
   int unsigned          heap_size    = 0;
   logic                 signed_order = 1'b0;

   req_item_type pending_items [$];
   rsp_item_type expected_rsps [$];
   int unsigned  fail_count   = 0;
   int unsigned  plan_size    = 0;
   logic         item_taken   = 1'b0;
   int unsigned  burst_left   = 1;
   int unsigned  gap_left     = 0;
   int unsigned  quiet_cycles = 0;

   function automatic logic key_less(logic [REQ_KEY_W-1:0] a, logic [REQ_KEY_W-1:0] b);
      // Flipping the sign bit turns two's complement order into unsigned order.
      if (signed_order)
         return {~a[REQ_KEY_W-1], a[REQ_KEY_W-2:0]} < {~b[REQ_KEY_W-1], b[REQ_KEY_W-2:0]};
      return a < b;
   endfunction

   function automatic void swap_keys(int unsigned a, int unsigned b);
      logic [REQ_KEY_W-1:0] held;
      held         = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = held;
   endfunction

   function automatic rsp_item_type apply_request(req_item_type req);
      rsp_item_type rsp;
      int unsigned  pos;
      int unsigned  parent;
      int unsigned  left;
      int unsigned  big;
      rsp        = '0;
      rsp.status = STATUS_OK;
      if (req.req_type == REQ_PUSH) begin
         if (heap_size >= DEPTH) begin
            rsp.status = STATUS_FULL;
         end else begin
            pos            = heap_size;
            heap_keys[pos] = req.key;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (!key_less(heap_keys[parent], heap_keys[pos]))
                  break;
               swap_keys(parent, pos);
               pos = parent;
            end
            heap_size++;
         end
      end else if (heap_size == 0) begin
         rsp.status = STATUS_EMPTY;
      end else begin
         rsp.popped_key = heap_keys[0];
         heap_size--;
         heap_keys[0] = heap_keys[heap_size];
         pos = 0;
         while (1) begin
            left = 2 * pos + 1;
            big  = pos;
            if (left >= heap_size)
               break;
            if (key_less(heap_keys[big], heap_keys[left]))
               big = left;
            if (left + 1 < heap_size && key_less(heap_keys[big], heap_keys[left + 1]))
               big = left + 1;
            if (big == pos)
               break;
            swap_keys(pos, big);
            pos = big;
         end
      end
      rsp.top_valid = (heap_size != 0);
      rsp.top_key   = (heap_size != 0) ? heap_keys[0] : '0;
      rsp.count     = heap_size[RSP_CNT_W-1:0];
      return rsp;
   endfunction

   task automatic check_field(string name, logic [REQ_KEY_W-1:0] want,
                              logic [REQ_KEY_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Results are compared as the DUT presents them; a new item is predicted
   // after the check so that the oldest expectation is always the one used.
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      item_taken <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected item, expected none, got %h", $time, rsp_item);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", want.status, rsp_item.status);
               check_field("popped_key", want.popped_key, rsp_item.popped_key);
               check_field("top_key", want.top_key, rsp_item.top_key);
               check_field("top_valid", want.top_valid, rsp_item.top_valid);
               check_field("count", want.count, rsp_item.count);
            end
         end
         if (start && !busy)
            expected_rsps.push_back(apply_request(req_item));
         if (csr_valid && csr_ready)
            signed_order = csr_key_signed;
      end
   end

   always @(negedge clock) begin : driver
      logic next_start;
      next_start = start && !item_taken;
      if (!next_start && !reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() > 0) begin
            req_item <= pending_items.pop_front();
            next_start = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end
      end
      start <= next_start;
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_item(logic op, logic [REQ_KEY_W-1:0] key);
      req_item_type item;
      item.req_type = op;
      item.key      = key;
      pending_items.push_back(item);
      if (op == REQ_PUSH && plan_size < DEPTH)
         plan_size++;
      else if (op == REQ_POP && plan_size > 0)
         plan_size--;
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || start || expected_rsps.size() != 0);
   endtask

   task automatic write_key_signed(logic value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_key_signed <= value;
      csr_valid      <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [REQ_KEY_W-1:0] rand_key();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 15);
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
         2: return 32'h7FFF_FFF0 + $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_mix(int unsigned n, int unsigned pop_pct);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < pop_pct)
            queue_item(REQ_POP, $urandom);
         else
            queue_item(REQ_PUSH, rand_key());
      end
   endtask

   initial begin : sequencer
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Unsigned order: empty pops, a pop that empties the heap, equal keys
      // and the extreme keys, then drain back past empty.
      write_key_signed(1'b0);
      queue_item(REQ_POP, 32'hFFFF_FFFF);
      queue_item(REQ_PUSH, 32'h0000_0000);
      queue_item(REQ_POP, 32'h0000_0000);
      queue_item(REQ_PUSH, 32'h0000_0005);
      queue_item(REQ_PUSH, 32'h0000_0005);
      queue_item(REQ_PUSH, 32'hFFFF_FFFF);
      queue_item(REQ_PUSH, 32'h8000_0000);
      queue_item(REQ_PUSH, 32'h7FFF_FFFF);
      queue_item(REQ_PUSH, 32'h0000_0000);
      repeat (7) queue_item(REQ_POP, 32'h0000_0000);

      // Signed order ranks the negative extremes below zero.
      write_key_signed(1'b1);
      queue_item(REQ_PUSH, 32'h7FFF_FFFF);
      queue_item(REQ_PUSH, 32'h8000_0000);
      queue_item(REQ_PUSH, 32'hFFFF_FFFF);
      queue_item(REQ_PUSH, 32'h0000_0000);
      repeat (5) queue_item(REQ_POP, 32'hFFFF_FFFF);

      run_mix(20, 50);

      // Switch order with keys still held, then fill the heap and push past full.
      write_key_signed(1'b0);
      while (plan_size < DEPTH) begin
         if ($urandom_range(0, 99) < 2)
            queue_item(REQ_POP, $urandom);
         else
            queue_item(REQ_PUSH, rand_key());
      end
      repeat (5) queue_item(REQ_PUSH, rand_key());
      queue_item(REQ_POP, $urandom);
      repeat (2) queue_item(REQ_PUSH, rand_key());

      write_key_signed(1'b1);
      run_mix(30, 85);
      run_mix(10, 50);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsps.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
design/bmhpq_pkg.sv
design/bmhpq_ctrl.sv
design/bmhpq_dp.sv
design/binary_max_heap_priority_queue_unit.sv
bench/binary_max_heap_priority_queue_unit_test.sv
